// ===== src/bcalt_pkg.sv =====
// Package: shared constants, tables and payload types for the barometric compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bcalt_pkg;

  localparam int DEF_MIN_PRESSURE = 10000;
  localparam int DEF_MAX_PRESSURE = 1200000;
  localparam int DEF_MIN_TEMP = -4000;
  localparam int DEF_MAX_TEMP = 8500;
  localparam int DEF_INTERP_FRACTION_BITS = 10;

  localparam int TAB_N = 8;

  // table pressures in hPa/1000, factor of entry i is 14 - i mm per hPa/1000
  localparam logic [20:0] TAB_P [TAB_N] = '{
    21'd1225005, 21'd1118311, 21'd1012049, 21'd909702,
    21'd808871, 21'd710051, 21'd614001, 21'd520296
  };

  // segment spans (entry i to i+1); last slot is never selected for a divide
  localparam logic [16:0] TAB_T [TAB_N] = '{
    17'd106694, 17'd106262, 17'd102347, 17'd100831,
    17'd98820, 17'd96050, 17'd93705, 17'd1
  };

  // floor(2^32 / span)
  localparam logic [16:0] RECIP [TAB_N] = '{
    17'(64'h1_0000_0000 / 64'd106694), 17'(64'h1_0000_0000 / 64'd106262),
    17'(64'h1_0000_0000 / 64'd102347), 17'(64'h1_0000_0000 / 64'd100831),
    17'(64'h1_0000_0000 / 64'd98820), 17'(64'h1_0000_0000 / 64'd96050),
    17'(64'h1_0000_0000 / 64'd93705), 17'd0
  };

  localparam logic [3:0] TOP_LOWER_FACTOR = 4'd13;
  localparam logic [3:0] LAST_FACTOR = 4'd7;

  // divide by ten: floor(2^25 / 10), input capped below 2^25
  localparam logic [21:0] RECIP10 = 22'(64'd33554432 / 64'd10);
  localparam logic [24:0] ALT_DIV_CAP = 25'd20000010;
  localparam logic [21:0] ALT_LIMIT = 22'd2000000;
  localparam logic [20:0] REF_P_RESET = 21'd1013250;

  typedef enum logic [2:0] {
    CFG_C1     = 3'd0,
    CFG_C2     = 3'd1,
    CFG_C3     = 3'd2,
    CFG_C4     = 3'd3,
    CFG_C5     = 3'd4,
    CFG_C6     = 3'd5,
    CFG_REF_P  = 3'd6,
    CFG_CAL_OK = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } calib_t;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [40:0] off;
    logic signed [40:0] sens;
    logic signed [14:0] tout;
  } comp_t;

  typedef struct packed {
    logic [20:0]        press;
    logic signed [14:0] tout;
  } press_t;

endpackage
`default_nettype wire

// ===== src/bcalt_comp.sv =====
// Temperature, offset and sensitivity pipeline with second-order correction.
`timescale 1ns / 1ps
`default_nettype none
module bcalt_comp #(
  parameter int MIN_TEMP = bcalt_pkg::DEF_MIN_TEMP,
  parameter int MAX_TEMP = bcalt_pkg::DEF_MAX_TEMP
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bcalt_pkg::calib_t calib,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic [23:0]      d1,
  input  wire logic [23:0]      d2,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output bcalt_pkg::comp_t      dn_data
);
  import bcalt_pkg::*;

  localparam int NS = 6;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? up_valid : v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  // stage 0: capture
  logic [23:0] d1_0_r, d2_0_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_0_r <= d1;
      d2_0_r <= d2;
    end
  end

  // stage 1: dT
  logic [23:0]        d1_1_r;
  logic signed [25:0] dt_1_r, dt_1_nxt;
  assign dt_1_nxt = $signed({2'b00, d2_0_r}) - $signed({2'b00, calib.c5, 8'd0});
  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_1_r <= d1_0_r;
      dt_1_r <= dt_1_nxt;
    end
  end

  // stage 2: products with dT
  logic [23:0]        d1_2_r;
  logic signed [42:0] mt_2_r, mt_2_nxt, mo_2_r, mo_2_nxt, ms_2_r, ms_2_nxt;
  logic signed [51:0] mdd_2_r, mdd_2_nxt;
  assign mt_2_nxt  = dt_1_r * $signed({1'b0, calib.c6});
  assign mo_2_nxt  = dt_1_r * $signed({1'b0, calib.c4});
  assign ms_2_nxt  = dt_1_r * $signed({1'b0, calib.c3});
  assign mdd_2_nxt = dt_1_r * dt_1_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_2_r  <= d1_1_r;
      mt_2_r  <= mt_2_nxt;
      mo_2_r  <= mo_2_nxt;
      ms_2_r  <= ms_2_nxt;
      mdd_2_r <= mdd_2_nxt;
    end
  end

  // stage 3: first-order terms
  logic [23:0]        d1_3_r;
  logic signed [19:0] temp_3_r, temp_3_nxt;
  logic signed [40:0] off_3_r, off_3_nxt, sens_3_r, sens_3_nxt;
  logic [19:0]        t2_3_r;
  assign temp_3_nxt = $signed(mt_2_r[42:23]) + 20'sd2000;
  assign off_3_nxt  = $signed({9'd0, calib.c2, 16'd0}) + 41'($signed(mo_2_r[42:7]));
  assign sens_3_nxt = $signed({10'd0, calib.c1, 15'd0}) + 41'($signed(ms_2_r[42:8]));
  always_ff @(posedge clk) begin
    if (en[3]) begin
      d1_3_r   <= d1_2_r;
      temp_3_r <= temp_3_nxt;
      off_3_r  <= off_3_nxt;
      sens_3_r <= sens_3_nxt;
      t2_3_r   <= mdd_2_r[50:31];
    end
  end

  // stage 4: squares for the low-temperature terms
  logic [23:0]        d1_4_r;
  logic signed [19:0] temp_4_r;
  logic signed [40:0] off_4_r, sens_4_r;
  logic [19:0]        t2_4_r;
  logic signed [19:0] ta, tb;
  logic signed [39:0] sqa_4_r, sqa_4_nxt, sqb_4_r, sqb_4_nxt;
  assign ta = temp_3_r - 20'sd2000;
  assign tb = temp_3_r + 20'sd1500;
  assign sqa_4_nxt = ta * ta;
  assign sqb_4_nxt = tb * tb;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      d1_4_r   <= d1_3_r;
      temp_4_r <= temp_3_r;
      off_4_r  <= off_3_r;
      sens_4_r <= sens_3_r;
      t2_4_r   <= t2_3_r;
      sqa_4_r  <= sqa_4_nxt;
      sqb_4_r  <= sqb_4_nxt;
    end
  end

  // stage 5: second-order correction, temperature clamp
  comp_t              out_r, out_nxt;
  logic signed [40:0] sqa_w, sqb_w, kk, n7, n11, off5, sens5;
  logic signed [20:0] tw, tc;
  logic               lt_low, lt_vlow;
  always_comb begin
    sqa_w   = 41'(sqa_4_r);
    sqb_w   = 41'(sqb_4_r);
    kk      = (sqa_w <<< 2) + sqa_w;
    n7      = (sqb_w <<< 3) - sqb_w;
    n11     = (sqb_w <<< 3) + (sqb_w <<< 1) + sqb_w;
    lt_low  = temp_4_r < 20'sd2000;
    lt_vlow = temp_4_r < -20'sd1500;
    off5    = off_4_r;
    sens5   = sens_4_r;
    if (lt_low) begin
      off5  = off5 - (kk >>> 1);
      sens5 = sens5 - (kk >>> 2);
      if (lt_vlow) begin
        off5  = off5 - n7;
        sens5 = sens5 - (n11 >>> 1);
      end
    end
    tw = 21'(temp_4_r) - (lt_low ? $signed({1'b0, t2_4_r}) : 21'sd0);
    if (tw < MIN_TEMP) begin
      tc = 21'(MIN_TEMP);
    end else if (tw > MAX_TEMP) begin
      tc = 21'(MAX_TEMP);
    end else begin
      tc = tw;
    end
    out_nxt.d1   = d1_4_r;
    out_nxt.off  = off5;
    out_nxt.sens = sens5;
    out_nxt.tout = 15'(tc);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_r <= out_nxt;
    end
  end

  assign dn_data = out_r;

endmodule
`default_nettype wire

// ===== src/bcalt_press.sv =====
// Pressure pipeline: split D1 x SENS product, offset, scale and clamp.
`timescale 1ns / 1ps
`default_nettype none
module bcalt_press #(
  parameter int MIN_PRESSURE = bcalt_pkg::DEF_MIN_PRESSURE,
  parameter int MAX_PRESSURE = bcalt_pkg::DEF_MAX_PRESSURE
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire bcalt_pkg::comp_t up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output bcalt_pkg::press_t     dn_data
);
  import bcalt_pkg::*;

  localparam int NS = 2;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? up_valid : v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  // stage 0: D1 x SENS as high (signed) and low (unsigned 21-bit) partial products
  logic [44:0]        pl_0_r, pl_0_nxt;
  logic signed [44:0] ph_0_r, ph_0_nxt;
  logic signed [40:0] off_0_r;
  logic signed [14:0] tout_0_r;
  logic [20:0]        sl;
  logic signed [19:0] sh;
  assign sl = up_data.sens[20:0];
  assign sh = up_data.sens[40:21];
  assign pl_0_nxt = 45'(up_data.d1) * 45'(sl);
  assign ph_0_nxt = $signed({1'b0, up_data.d1}) * sh;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_0_r   <= pl_0_nxt;
      ph_0_r   <= ph_0_nxt;
      off_0_r  <= up_data.off;
      tout_0_r <= up_data.tout;
    end
  end

  // stage 1: ((D1*SENS >> 21) - OFF) * 10 >> 15, clamp
  press_t             out_r, out_nxt;
  logic signed [45:0] xx;
  logic signed [46:0] yy;
  logic signed [50:0] zz;
  logic signed [35:0] pp;
  always_comb begin
    xx = 46'(ph_0_r) + $signed({22'd0, pl_0_r[44:21]});
    yy = 47'(xx) - 47'(off_0_r);
    zz = (51'(yy) <<< 3) + (51'(yy) <<< 1);
    pp = zz[50:15];
    if (pp < MIN_PRESSURE) begin
      out_nxt.press = 21'(MIN_PRESSURE);
    end else if (pp > MAX_PRESSURE) begin
      out_nxt.press = 21'(MAX_PRESSURE);
    end else begin
      out_nxt.press = pp[20:0];
    end
    out_nxt.tout = tout_0_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_r <= out_nxt;
    end
  end

  assign dn_data = out_r;

endmodule
`default_nettype wire

// ===== src/bcalt_alt.sv =====
// Altitude pipeline: table segment, interpolated factor, scaling and divide by ten.
`timescale 1ns / 1ps
`default_nettype none
module bcalt_alt #(
  parameter int MIN_PRESSURE         = bcalt_pkg::DEF_MIN_PRESSURE,
  parameter int MIN_TEMP             = bcalt_pkg::DEF_MIN_TEMP,
  parameter int INTERP_FRACTION_BITS = bcalt_pkg::DEF_INTERP_FRACTION_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [20:0]       ref_p,
  input  wire logic              cal_ok,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire bcalt_pkg::press_t up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output logic [20:0]            dn_press,
  output logic signed [21:0]     dn_alt,
  output logic signed [14:0]     dn_temp
);
  import bcalt_pkg::*;

  localparam int NS = 7;
  localparam int FB = INTERP_FRACTION_BITS;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? up_valid : v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  // stage 0: segment select; above the first point the first segment extrapolates
  logic [2:0]         up, lo;
  logic [20:0]        ld;
  press_t             pt_0_r, pt_1_r, pt_2_r, pt_3_r, pt_4_r, pt_5_r;
  logic [31:0]        x_0_r, x_0_nxt, x_1_r;
  logic [2:0]         seg_0_r, seg_1_r;
  logic               last_0_r, last_1_r;
  logic [15:0]        base_0_r, base_0_nxt, base_1_r;
  logic signed [21:0] delta_0_r, delta_0_nxt, delta_1_r, delta_2_r;
  always_comb begin
    up = '0;
    for (int k = 1; k < TAB_N; k++) begin
      if (up_data.press <= TAB_P[k]) begin
        up = 3'(k);
      end
    end
    lo          = up + 3'd1;
    ld          = up_data.press - TAB_P[lo];
    x_0_nxt     = 32'(ld) << FB;
    base_0_nxt  = 16'(TOP_LOWER_FACTOR - {1'b0, up}) << FB;
    delta_0_nxt = $signed({1'b0, ref_p}) - $signed({1'b0, up_data.press});
  end
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pt_0_r    <= up_data;
      x_0_r     <= x_0_nxt;
      seg_0_r   <= up;
      last_0_r  <= (up == 3'(TAB_N - 1));
      base_0_r  <= base_0_nxt;
      delta_0_r <= delta_0_nxt;
    end
  end

  // stage 1: quotient estimate by reciprocal, may be one low
  logic [48:0] qp;
  logic [16:0] qe_1_r;
  assign qp = 49'(x_0_r) * 49'(RECIP[seg_0_r]);
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pt_1_r    <= pt_0_r;
      x_1_r     <= x_0_r;
      seg_1_r   <= seg_0_r;
      last_1_r  <= last_0_r;
      base_1_r  <= base_0_r;
      delta_1_r <= delta_0_r;
      qe_1_r    <= qp[48:32];
    end
  end

  // stage 2: remainder correction, factor
  logic [33:0] qt, rem;
  logic        corr;
  logic [15:0] factor_2_r, factor_2_nxt;
  always_comb begin
    qt   = 34'(qe_1_r) * 34'(TAB_T[seg_1_r]);
    rem  = 34'(x_1_r) - qt;
    corr = rem >= 34'(TAB_T[seg_1_r]);
    if (last_1_r) begin
      factor_2_nxt = 16'(LAST_FACTOR) << FB;
    end else begin
      factor_2_nxt = base_1_r + 16'(qe_1_r) + 16'(corr);
    end
  end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pt_2_r     <= pt_1_r;
      delta_2_r  <= delta_1_r;
      factor_2_r <= factor_2_nxt;
    end
  end

  // stage 3: delta x factor
  logic signed [38:0] mm_3_r, mm_3_nxt;
  assign mm_3_nxt = delta_2_r * $signed({1'b0, factor_2_r});
  always_ff @(posedge clk) begin
    if (en[3]) begin
      pt_3_r <= pt_2_r;
      mm_3_r <= mm_3_nxt;
    end
  end

  // stage 4: drop fraction (floor), take magnitude, cap above the saturation point
  logic signed [38:0] mmf;
  logic [38:0]        mag;
  logic [24:0]        ac_4_r, ac_4_nxt;
  logic               neg_4_r, neg_5_r;
  always_comb begin
    mmf = mm_3_r >>> FB;
    mag = mmf[38] ? 39'(-mmf) : 39'(mmf);
    ac_4_nxt = (mag > 39'(ALT_DIV_CAP)) ? ALT_DIV_CAP : mag[24:0];
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      pt_4_r  <= pt_3_r;
      ac_4_r  <= ac_4_nxt;
      neg_4_r <= mmf[38];
    end
  end

  // stage 5: quotient estimate of magnitude / 10
  logic [46:0] tp;
  logic [24:0] ac_5_r;
  logic [21:0] q_5_r;
  assign tp = 47'(ac_4_r) * 47'(RECIP10);
  always_ff @(posedge clk) begin
    if (en[5]) begin
      pt_5_r  <= pt_4_r;
      ac_5_r  <= ac_4_r;
      neg_5_r <= neg_4_r;
      q_5_r   <= tp[46:25];
    end
  end

  // stage 6: correction, saturate, sign, invalid-calibration override
  logic [24:0]        r10;
  logic [21:0]        qf, qs;
  logic [20:0]        press_6_r, press_6_nxt;
  logic signed [21:0] alt_6_r, alt_6_nxt;
  logic signed [14:0] temp_6_r, temp_6_nxt;
  always_comb begin
    r10 = ac_5_r - ((25'(q_5_r) << 3) + (25'(q_5_r) << 1));
    qf  = q_5_r + 22'(r10 >= 25'd10);
    qs  = (qf > ALT_LIMIT) ? ALT_LIMIT : qf;
    if (cal_ok) begin
      press_6_nxt = pt_5_r.press;
      alt_6_nxt   = neg_5_r ? -$signed(qs) : $signed(qs);
      temp_6_nxt  = pt_5_r.tout;
    end else begin
      press_6_nxt = 21'(MIN_PRESSURE);
      alt_6_nxt   = '0;
      temp_6_nxt  = 15'(MIN_TEMP);
    end
  end
  always_ff @(posedge clk) begin
    if (en[6]) begin
      press_6_r <= press_6_nxt;
      alt_6_r   <= alt_6_nxt;
      temp_6_r  <= temp_6_nxt;
    end
  end

  assign dn_press = press_6_r;
  assign dn_alt   = alt_6_r;
  assign dn_temp  = temp_6_r;

  a_seg_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && !last_1_r) |-> (rem < (34'(TAB_T[seg_1_r]) << 1)))
    else $error("segment divide remainder out of range");

  a_ten_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] |-> (r10 < 25'd20))
    else $error("divide by ten remainder out of range");

  a_alt_lim: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid |-> ((dn_alt <= $signed({1'b0, ALT_LIMIT[20:0]}))
               && (dn_alt >= -$signed({1'b0, ALT_LIMIT[20:0]}))))
    else $error("altitude beyond saturation limit");

endmodule
`default_nettype wire

// ===== src/baro_compensation_altitude.sv =====
// Top level: configuration registers and the compensation / altitude pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw pressure / temperature conversion pair per clock while in_stall is low and
// returns the compensated pressure (hPa/1000), temperature (0.01 degC) and altitude above
// reference_pressure (cm), one transaction per cycle sustained while out_stall is low, through
// three pipelines: 6 stages of temperature/offset/sensitivity, 2 of pressure, 7 of altitude
// (segment divide by reciprocal and divide by ten). Each stage holds its own valid bit and holds
// its data only when full and the next stage cannot take it, so out_stall backs up into in_stall
// and bubbles are squeezed out. Calibration words are written through cfg_we/cfg_index/cfg_wdata;
// the user must do so only while the block is idle, which the block itself does not enforce. With
// calibration_ok at 0 the outputs are minimum pressure, zero altitude and minimum temperature.
module baro_compensation_altitude #(
  parameter int MIN_PRESSURE         = bcalt_pkg::DEF_MIN_PRESSURE,
  parameter int MAX_PRESSURE         = bcalt_pkg::DEF_MAX_PRESSURE,
  parameter int MIN_TEMP             = bcalt_pkg::DEF_MIN_TEMP,
  parameter int MAX_TEMP             = bcalt_pkg::DEF_MAX_TEMP,
  parameter int INTERP_FRACTION_BITS = bcalt_pkg::DEF_INTERP_FRACTION_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [23:0]        in_pressure_raw,
  input  wire logic [23:0]        in_temperature_raw,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [20:0]             out_pressure,
  output logic signed [21:0]      out_altitude,
  output logic signed [14:0]      out_temperature,
  input  wire logic               cfg_we,
  input  wire bcalt_pkg::cfg_idx_t cfg_index,
  input  wire logic [20:0]        cfg_wdata
);
  import bcalt_pkg::*;

  calib_t      calib_r;
  logic [20:0] ref_p_r;
  logic        cal_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r  <= '0;
      ref_p_r  <= REF_P_RESET;
      cal_ok_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_C1:     calib_r.c1 <= cfg_wdata[15:0];
        CFG_C2:     calib_r.c2 <= cfg_wdata[15:0];
        CFG_C3:     calib_r.c3 <= cfg_wdata[15:0];
        CFG_C4:     calib_r.c4 <= cfg_wdata[15:0];
        CFG_C5:     calib_r.c5 <= cfg_wdata[15:0];
        CFG_C6:     calib_r.c6 <= cfg_wdata[15:0];
        CFG_REF_P:  ref_p_r    <= cfg_wdata;
        CFG_CAL_OK: cal_ok_r   <= cfg_wdata[0];
        default:    cal_ok_r   <= cal_ok_r;
      endcase
    end
  end

  logic   comp_ready, comp_valid, press_ready, press_valid, alt_ready;
  comp_t  comp_data;
  press_t press_data;

  bcalt_comp #(
    .MIN_TEMP (MIN_TEMP),
    .MAX_TEMP (MAX_TEMP)
  ) u_comp (
    .clk      (clk),
    .rst_n    (rst_n),
    .calib    (calib_r),
    .up_valid (in_valid),
    .up_ready (comp_ready),
    .d1       (in_pressure_raw),
    .d2       (in_temperature_raw),
    .dn_valid (comp_valid),
    .dn_ready (press_ready),
    .dn_data  (comp_data)
  );

  bcalt_press #(
    .MIN_PRESSURE (MIN_PRESSURE),
    .MAX_PRESSURE (MAX_PRESSURE)
  ) u_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (comp_valid),
    .up_ready (press_ready),
    .up_data  (comp_data),
    .dn_valid (press_valid),
    .dn_ready (alt_ready),
    .dn_data  (press_data)
  );

  bcalt_alt #(
    .MIN_PRESSURE         (MIN_PRESSURE),
    .MIN_TEMP             (MIN_TEMP),
    .INTERP_FRACTION_BITS (INTERP_FRACTION_BITS)
  ) u_alt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ref_p    (ref_p_r),
    .cal_ok   (cal_ok_r),
    .up_valid (press_valid),
    .up_ready (alt_ready),
    .up_data  (press_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_press (out_pressure),
    .dn_alt   (out_altitude),
    .dn_temp  (out_temperature)
  );

  assign in_stall = !comp_ready;

endmodule
`default_nettype wire
